### src/ati_pkg.sv
// Shared types and constants for the attribute tween interpolator.
`default_nettype none
package ati_pkg;

    localparam int DUR_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int COL_W    = 9;
    localparam int COLPK_W  = 36;
    localparam int R_W      = 17;   // Q1.16 progress, one means 65536
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 36;
    localparam int QUO_W    = 48;   // dividend is time << 16

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_FINAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_FINAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COL_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COL_FINAL  = 3'd7;

    // status codes
    localparam logic [2:0] ST_APPLIED = 3'd0;
    localparam logic [2:0] ST_LEAVE   = 3'd1;
    localparam logic [2:0] ST_RESTORE = 3'd2;
    localparam logic [2:0] ST_KILL    = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    localparam logic [DUR_W-1:0]   DURATION_RESET = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET     = 16'd4096;
    localparam logic [COLPK_W-1:0] COLOUR_RESET   = 36'd34426978560;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;      // latch input item, clear time
        logic add_time;     // accumulate elapsed ticks
        logic div_start;    // load divider
        logic div_step;     // one quotient bit
        logic fold_r;       // load or fold progress into r register
        logic r_zero;       // use progress zero
        logic mul_stage;    // advance product sequencer
        logic [2:0] mul_sel;
        logic load_out;     // write result register
        logic [2:0] out_status;
    } ati_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic ended;        // time reached duration, or duration is zero
        logic running;
    } ati_sts_t;

endpackage
`default_nettype wire

### src/ati_datapath.sv
// Datapath: time counter, serial divider, shared multiplier, result register.
`default_nettype none
module ati_datapath
    import ati_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_data,
    input  wire logic [15:0]           in_elapsed,
    input  wire logic [15:0]           in_width,
    input  wire logic [15:0]           in_height,
    input  wire logic [15:0]           in_angle,
    input  wire logic [8:0]            in_opacity,
    input  wire logic [8:0]            in_red,
    input  wire logic [8:0]            in_green,
    input  wire logic [8:0]            in_blue,
    input  wire ati_cmd_t              cmd,
    output ati_sts_t                   sts,
    output logic [2:0]                 mode,
    output logic [86:0]                result
);

    // configuration registers
    logic [DUR_W-1:0]   dur_reg;
    logic [2:0]         mode_reg;
    logic [15:0]        sf0_reg, sf1_reg, ao0_reg, ao1_reg;
    logic [COLPK_W-1:0] c0_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg  <= DURATION_RESET;
            mode_reg <= '0;
            sf0_reg  <= SIZE_RESET;
            sf1_reg  <= SIZE_RESET;
            ao0_reg  <= '0;
            ao1_reg  <= '0;
            c0_reg   <= COLOUR_RESET;
            c1_reg   <= COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DURATION:   dur_reg  <= cfg_data[31:0];
                REG_MODE:       mode_reg <= cfg_data[2:0];
                REG_SIZE_START: sf0_reg  <= cfg_data[15:0];
                REG_SIZE_FINAL: sf1_reg  <= cfg_data[15:0];
                REG_ANG_START:  ao0_reg  <= cfg_data[15:0];
                REG_ANG_FINAL:  ao1_reg  <= cfg_data[15:0];
                REG_COL_START:  c0_reg   <= cfg_data;
                REG_COL_FINAL:  c1_reg   <= cfg_data;
                default: ;
            endcase
        end
    end
    assign mode = mode_reg;

    // effect state
    logic [DUR_W-1:0] time_reg;
    logic             run_reg;
    logic [15:0]      kw_reg, kh_reg, ka_reg;
    logic [8:0]       ko_reg, kr_reg, kg_reg, kb_reg;
    logic [DUR_W:0]   time_sum;

    assign time_sum = {1'b0, time_reg} + {17'd0, in_elapsed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            run_reg  <= 1'b0;
            kw_reg <= '0; kh_reg <= '0; ka_reg <= '0;
            ko_reg <= '0; kr_reg <= '0; kg_reg <= '0; kb_reg <= '0;
        end
        else if (cmd.capture)
        begin
            time_reg <= '0;
            run_reg  <= 1'b1;
            kw_reg <= in_width;   kh_reg <= in_height; ka_reg <= in_angle;
            ko_reg <= in_opacity; kr_reg <= in_red;
            kg_reg <= in_green;   kb_reg <= in_blue;
        end
        else if (cmd.add_time)
        begin
            time_reg <= time_sum[DUR_W] ? '1 : time_sum[DUR_W-1:0];
        end
        else if (cmd.load_out && cmd.out_status != ST_APPLIED)
        begin
            run_reg <= 1'b0;
        end
    end

    assign sts.ended   = (time_reg >= dur_reg) || (dur_reg == '0);
    assign sts.running = run_reg;

    // restoring divider: (time << 16) / duration, one quotient bit a cycle
    logic [QUO_W-1:0] quo_reg;
    logic [DUR_W:0]   rem_reg;
    logic [DUR_W:0]   rem_sh;
    logic [DUR_W+1:0] rem_try;

    assign rem_sh  = {rem_reg[DUR_W-1:0], quo_reg[QUO_W-1]};
    assign rem_try = {1'b0, rem_sh} - {2'b0, dur_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {time_reg, 16'd0};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_try[DUR_W+1])
            begin
                rem_reg <= rem_try[DUR_W:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    // progress, folded in loop-back mode; below duration it is < 65536
    logic [R_W-1:0] r_reg;
    logic [R_W:0]   r2;
    assign r2 = {1'b0, quo_reg[15:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.r_zero)
            r_reg <= '0;
        else if (cmd.fold_r)
        begin
            if (!mode_reg[0])
                r_reg <= {1'b0, quo_reg[15:0]};
            else if (r2 > 18'd65536)
                r_reg <= R_W'(18'd131072 - r2);
            else
                r_reg <= r2[R_W-1:0];
        end
    end

    // shared multiplier sequencer: each mul_sel step does one lerp product
    // pair then one scale product, registered between.
    logic [R_W-1:0] rinv;
    assign rinv = R_W'(18'd65536 - {1'b0, r_reg});

    logic [15:0] fa, fb;
    logic [15:0] base;
    always_comb
    begin
        fa = sf0_reg; fb = sf1_reg; base = kw_reg;
        case (cmd.mul_sel)
            3'd0: begin fa = sf0_reg; fb = sf1_reg; base = kw_reg; end
            3'd1: begin fa = sf0_reg; fb = sf1_reg; base = kh_reg; end
            3'd2: begin fa = {7'd0, c0_reg[35:27]}; fb = {7'd0, c1_reg[35:27]};
                        base = {7'd0, ko_reg}; end
            3'd3: begin fa = {7'd0, c0_reg[8:0]};   fb = {7'd0, c1_reg[8:0]};
                        base = {7'd0, kr_reg}; end
            3'd4: begin fa = {7'd0, c0_reg[17:9]};  fb = {7'd0, c1_reg[17:9]};
                        base = {7'd0, kg_reg}; end
            3'd5: begin fa = {7'd0, c0_reg[26:18]}; fb = {7'd0, c1_reg[26:18]};
                        base = {7'd0, kb_reg}; end
            default: ;
        endcase
    end

    // stage 1: factor lerp
    logic [33:0] lerp_sum;
    logic [17:0] f_reg;
    logic [15:0] base_reg;
    logic [2:0]  sel_reg;
    assign lerp_sum = 34'(fa * rinv) + 34'(fb * r_reg) + 34'd32768;

    // stage 2: scale
    logic [33:0] scaled;
    logic [21:0] sz_v;
    logic [25:0] cl_v;
    assign scaled = 34'(base_reg * f_reg);
    assign sz_v = 22'((scaled + 34'd2048) >> 12);
    assign cl_v = 26'((scaled + 34'd128) >> 8);

    // angle: (s1 - s0) * r, rounded, floored
    logic signed [16:0] adiff;
    logic signed [35:0] aprod;
    logic [15:0]        aoff;
    assign adiff = $signed({ao1_reg[15], ao1_reg}) - $signed({ao0_reg[15], ao0_reg});
    assign aprod = adiff * $signed({1'b0, r_reg}) + 36'sd32768;
    assign aoff  = aprod[31:16];

    logic [15:0] ow_reg, oh_reg, oa_reg;
    logic [8:0]  oo_reg, or_reg, og_reg, ob_reg;
    logic        s2_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_stage)
        begin
            f_reg    <= lerp_sum[33:16];
            base_reg <= base;
            sel_reg  <= cmd.mul_sel;
        end
        s2_vld_reg <= cmd.mul_stage;
        if (s2_vld_reg)
        begin
            case (sel_reg)
                3'd0: ow_reg <= (sz_v > 22'd65535) ? 16'hFFFF : sz_v[15:0];
                3'd1: oh_reg <= (sz_v > 22'd65535) ? 16'hFFFF : sz_v[15:0];
                3'd2: oo_reg <= (cl_v > 26'd256) ? 9'd256 : cl_v[8:0];
                3'd3: or_reg <= (cl_v > 26'd256) ? 9'd256 : cl_v[8:0];
                3'd4: og_reg <= (cl_v > 26'd256) ? 9'd256 : cl_v[8:0];
                3'd5: ob_reg <= (cl_v > 26'd256) ? 9'd256 : cl_v[8:0];
                default: ;
            endcase
            oa_reg <= ka_reg + aoff;
        end
    end

    // result register: status, w, h, angle, opacity, r, g, b from bit 0 up
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_status)
                ST_APPLIED: result <= {ob_reg, og_reg, or_reg, oo_reg,
                                       oa_reg, oh_reg, ow_reg, ST_APPLIED};
                ST_RESTORE: result <= {kb_reg, kg_reg, kr_reg, ko_reg,
                                       ka_reg, kh_reg, kw_reg, ST_RESTORE};
                default:    result <= {84'd0, cmd.out_status};
            endcase
        end
    end

endmodule
`default_nettype wire

### src/ati_ctrl.sv
// Controller: sequences tick/start handling, divider and product steps.
`default_nettype none
module ati_ctrl
    import ati_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic     in_op,
    input  wire ati_sts_t sts,
    input  wire logic [2:0] mode,
    input  wire logic     out_free,
    output logic          busy,
    output logic          out_load,
    output ati_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] stat_reg, stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stat_reg  <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.mul_sel = cnt_reg[2:0];
        cmd.out_status = stat_reg;
        out_load   = 1'b0;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_op)
                    begin
                        cmd.capture = 1'b1;
                        cmd.r_zero  = 1'b1;
                        stat_next   = ST_APPLIED;
                        cnt_next    = '0;
                        state_next  = S_MUL;
                    end
                    else if (!sts.running)
                    begin
                        stat_next  = ST_IDLE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.add_time = 1'b1;
                        state_next   = S_TICK;
                    end
                end
            end
            S_TICK:
            begin
                cnt_next = '0;
                if (sts.ended)
                begin
                    stat_next  = mode[1] ? ST_KILL : (mode[2] ? ST_RESTORE : ST_LEAVE);
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    stat_next     = ST_APPLIED;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold_r = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // six products issued, then the pipeline drains
                cmd.mul_stage = (cnt_reg < 6'd6);
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd7)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    out_load     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### src/attribute_tween_interpolator.sv
// Top level of the sprite attribute tween interpolator.
// A running tick is dominated by the restoring divider, then the product
// sequence; a start skips the divider, and output stalls add delay.
// Throughput: one transaction at a time; next accepted once the result
// register is loaded (it may still be waiting on m_axis_tready).
// Reset: rst_n asynchronous active low; config and control registers take their default values.
`default_nettype none
module attribute_tween_interpolator
    import ati_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // elapsed_ticks, base_width, base_height, base_angle, base_opacity,
    // base_red, base_green, base_blue
    input  wire logic [103:0]         s_axis_tdata,
    // opcode
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // status, out_width, out_height, out_angle, out_opacity, out_red,
    // out_green, out_blue, zero pad
    output logic [87:0]               m_axis_tdata
);

    ati_cmd_t     cmd;
    ati_sts_t     sts;
    logic [2:0]   mode;
    logic         busy, out_load, in_fire, out_free;
    logic [86:0]  result;
    logic         mvld_reg;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !mvld_reg || m_axis_tready;

    ati_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(s_axis_tuser),
        .sts(sts), .mode(mode), .out_free(out_free), .busy(busy),
        .out_load(out_load), .cmd(cmd)
    );

    ati_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_elapsed(s_axis_tdata[15:0]),  .in_width(s_axis_tdata[31:16]),
        .in_height(s_axis_tdata[47:32]),  .in_angle(s_axis_tdata[63:48]),
        .in_opacity(s_axis_tdata[72:64]), .in_red(s_axis_tdata[81:73]),
        .in_green(s_axis_tdata[90:82]),   .in_blue(s_axis_tdata[99:91]),
        .cmd(cmd), .sts(sts), .mode(mode), .result(result)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvld_reg <= 1'b0;
        else if (out_load)
            mvld_reg <= 1'b1;
        else if (m_axis_tready)
            mvld_reg <= 1'b0;
    end

    assign m_axis_tvalid = mvld_reg;
    // result holds status in 2:0, then the fields
    assign m_axis_tdata  = {1'b0, result};

    // a load only happens when the output slot is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free) else $error("result overwritten");
    // no transaction accepted while sequencing
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("accepted while busy");
    // each load raises valid next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid) else $error("valid missing");

endmodule
`default_nettype wire
